// ----- rtl/core/bmp_rle8_palette_decoder_macros.svh -----
// Assertion helpers shared by the decoder modules.
// Both expect i_clk and i_rst_n in the scope where they are used.
`ifndef BMP_RLE8_PALETTE_DECODER_MACROS_SVH
`define BMP_RLE8_PALETTE_DECODER_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define BMPRLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define BMPRLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/bmprle_pkg.sv -----
package bmprle_pkg;

    // Palette geometry
    localparam int PAL_DEPTH = 256;
    localparam int PAL_AW    = 8;
    localparam int COLOR_W   = 24;

    // Result field widths
    localparam int START_W = 24;
    localparam int LEN_W   = 25;
    localparam logic [START_W-1:0] START_MAX = 24'hFFFFFF;

    // Config port
    localparam int CFG_DW = 13;
    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    // Input item kinds
    localparam logic [1:0] KIND_PALETTE = 2'd0;
    localparam logic [1:0] KIND_BYTE    = 2'd1;
    localparam logic [1:0] KIND_START   = 2'd2;

    // Result kinds
    localparam logic [1:0] RES_FILL = 2'd0;
    localparam logic [1:0] RES_RUN  = 2'd1;
    localparam logic [1:0] RES_EOB  = 2'd2;

    // Escape codes after a zero count byte
    localparam logic [7:0] ESC_EOL   = 8'd0;
    localparam logic [7:0] ESC_EOB   = 8'd1;
    localparam logic [7:0] ESC_DELTA = 8'd2;

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_VALUE   = 3'd1,
        PH_ESCAPE  = 3'd2,
        PH_DELTA_X = 3'd3,
        PH_DELTA_Y = 3'd4,
        PH_LITERAL = 3'd5,
        PH_PAD     = 3'd6
    } t_phase;

    // Result descriptor produced by the parser, before the palette lookup
    typedef struct packed {
        logic [1:0]         kind;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
        logic               zero_color;
    } t_meta;

    // Finished result item
    typedef struct packed {
        logic [1:0]         kind;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
        logic [COLOR_W-1:0] color;
    } t_result;

endpackage

// ----- rtl/core/bmprle_palette_ram.sv -----
module bmprle_palette_ram (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [bmprle_pkg::PAL_AW-1:0]     i_waddr,
    input  logic [bmprle_pkg::COLOR_W-1:0]    i_wdata,
    input  logic                              i_re,
    input  logic [bmprle_pkg::PAL_AW-1:0]     i_raddr,
    output logic [bmprle_pkg::COLOR_W-1:0]    o_rdata
);

    logic [bmprle_pkg::COLOR_W-1:0] mem [bmprle_pkg::PAL_DEPTH];
    logic [bmprle_pkg::COLOR_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds its data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/bmprle_rem_unit.sv -----
`include "bmp_rle8_palette_decoder_macros.svh"

module bmprle_rem_unit #(
    parameter int EW = 13,
    parameter int PW = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [PW-1:0] i_dividend,
    input  logic [EW-1:0] i_divisor,
    output logic          o_busy,
    output logic          o_done,
    output logic [EW-1:0] o_rem
);

    localparam int CW = (PW > 1) ? $clog2(PW) : 1;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt,  n_cnt;
    logic [EW-1:0] r_rem,  n_rem;

    logic [EW:0]   w_shift;
    logic [EW:0]   w_sub;
    logic          w_ge;
    logic [EW-1:0] w_step;

    // One restoring step: bring in the next dividend bit, subtract if it fits
    always_comb begin
        w_shift = {r_rem, i_dividend[r_cnt]};
        w_sub   = w_shift - {1'b0, i_divisor};
        w_ge    = (w_shift >= {1'b0, i_divisor});
        w_step  = w_ge ? w_sub[EW-1:0] : w_shift[EW-1:0];
    end

    // Sequence the steps from the top bit down
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(PW - 1);
            n_rem  = '0;
        end else if (r_busy) begin
            n_rem = w_step;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_rem  = r_rem;

    `BMPRLE_ASSERT_NOW(a_rem_no_restart, i_start, !r_busy && !r_done, "rem unit restarted while active")
    `BMPRLE_ASSERT_NOW(a_rem_done_after_busy, r_done, $past(r_busy), "rem done without a pass")

endmodule

// ----- rtl/core/bmprle_parser.sv -----
module bmprle_parser #(
    parameter int EW = 13,
    parameter int PW = 25
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [1:0]                    i_kind,
    input  logic [7:0]                    i_byte,
    input  logic [EW-1:0]                 i_eff_w,
    input  logic [PW-1:0]                 i_frame,
    input  logic                          i_rem_done,
    input  logic [EW-1:0]                 i_rem,
    output logic                          o_meta_valid,
    output bmprle_pkg::t_meta             o_meta,
    output logic [bmprle_pkg::PAL_AW-1:0] o_rd_addr,
    output logic                          o_rem_start,
    output logic [PW-1:0]                 o_pos
);

    localparam int DW = EW + 9;
    localparam int SW = ((PW > DW) ? PW : DW) + 1;

    bmprle_pkg::t_phase r_phase, n_phase;
    logic [7:0]    r_held, n_held;
    logic [7:0]    r_dcol, n_dcol;
    logic [7:0]    r_lit,  n_lit;
    logic          r_pad,  n_pad;
    logic [PW-1:0] r_pos,  n_pos;
    logic          r_done, n_done;
    logic          r_dpend, n_dpend;
    logic [DW-1:0] r_dadd, n_dadd;

    logic          w_is_byte;
    logic          w_start;
    logic [7:0]    w_run_n;
    logic [PW:0]   w_run_sum;
    logic [PW-1:0] w_run_pos;
    logic          w_in_frame;
    logic [PW-1:0] w_room;
    logic [7:0]    w_run_len;
    logic [EW+7:0] w_dprod;
    logic [DW-1:0] w_dadd_n;
    logic [SW-1:0] w_dsum;
    logic [PW-1:0] w_dpos;
    logic [PW-1:0] w_eol_pos;
    logic [7:0]    w_lit_dec;

    // Datapath shared by the phases
    always_comb begin
        w_is_byte  = i_accept && (i_kind == bmprle_pkg::KIND_BYTE) && !r_done;
        w_start    = i_accept && (i_kind == bmprle_pkg::KIND_START);
        w_run_n    = (r_phase == bmprle_pkg::PH_VALUE) ? r_held : 8'd1;
        w_run_sum  = {1'b0, r_pos} + (PW+1)'(w_run_n);
        w_run_pos  = (w_run_sum > {1'b0, i_frame}) ? i_frame : w_run_sum[PW-1:0];
        w_in_frame = (r_pos < i_frame);
        w_room     = i_frame - r_pos;
        w_run_len  = (64'(w_room) < 64'(w_run_n)) ? 8'(w_room) : w_run_n;
        w_dprod    = (EW+8)'(i_byte) * (EW+8)'(i_eff_w);
        w_dadd_n   = DW'(w_dprod) + DW'(r_dcol);
        w_dsum     = SW'(r_pos) + SW'(r_dadd);
        w_dpos     = (w_dsum > SW'(i_frame)) ? i_frame : PW'(w_dsum);
        w_eol_pos  = r_pos + PW'(i_eff_w - i_rem);
        w_lit_dec  = r_lit - 8'd1;
    end

    // Next parse phase
    always_comb begin
        n_phase = r_phase;
        if (w_start) begin
            n_phase = bmprle_pkg::PH_FIRST;
        end else if (w_is_byte) begin
            unique case (r_phase)
                bmprle_pkg::PH_FIRST: begin
                    n_phase = (i_byte == 8'd0) ? bmprle_pkg::PH_ESCAPE : bmprle_pkg::PH_VALUE;
                end
                bmprle_pkg::PH_ESCAPE: begin
                    unique case (i_byte)
                        bmprle_pkg::ESC_EOL:   n_phase = bmprle_pkg::PH_FIRST;
                        bmprle_pkg::ESC_EOB:   n_phase = bmprle_pkg::PH_FIRST;
                        bmprle_pkg::ESC_DELTA: n_phase = bmprle_pkg::PH_DELTA_X;
                        default:               n_phase = bmprle_pkg::PH_LITERAL;
                    endcase
                end
                bmprle_pkg::PH_DELTA_X: n_phase = bmprle_pkg::PH_DELTA_Y;
                bmprle_pkg::PH_LITERAL: begin
                    if (w_lit_dec == 8'd0) begin
                        n_phase = r_pad ? bmprle_pkg::PH_PAD : bmprle_pkg::PH_FIRST;
                    end
                end
                default: n_phase = bmprle_pkg::PH_FIRST;
            endcase
        end
    end

    // Parse registers, position and result descriptor
    always_comb begin
        n_held       = r_held;
        n_dcol       = r_dcol;
        n_lit        = r_lit;
        n_pad        = r_pad;
        n_pos        = r_pos;
        n_done       = r_done;
        n_dpend      = 1'b0;
        n_dadd       = r_dadd;
        o_meta_valid = 1'b0;
        o_meta       = '0;
        o_rd_addr    = '0;
        o_rem_start  = 1'b0;

        // Finish a delta skip or a line end left over from earlier bytes
        if (r_dpend) begin
            n_pos = w_dpos;
        end
        if (i_rem_done && (i_rem != '0)) begin
            n_pos = w_eol_pos;
        end

        if (w_start) begin
            n_held       = '0;
            n_dcol       = '0;
            n_lit        = '0;
            n_pad        = 1'b0;
            n_pos        = '0;
            n_done       = 1'b0;
            o_meta_valid = 1'b1;
            o_meta.kind  = bmprle_pkg::RES_FILL;
            o_meta.len   = bmprle_pkg::LEN_W'(i_frame);
        end else if (w_is_byte) begin
            unique case (r_phase)
                bmprle_pkg::PH_FIRST: n_held = i_byte;
                bmprle_pkg::PH_VALUE, bmprle_pkg::PH_LITERAL: begin
                    n_pos = w_run_pos;
                    if (r_phase == bmprle_pkg::PH_LITERAL) begin
                        n_lit = w_lit_dec;
                    end
                    if (w_in_frame) begin
                        o_meta_valid = 1'b1;
                        o_meta.kind  = bmprle_pkg::RES_RUN;
                        o_meta.start = bmprle_pkg::START_W'(r_pos);
                        o_meta.len   = bmprle_pkg::LEN_W'(w_run_len);
                        o_rd_addr    = i_byte;
                    end
                end
                bmprle_pkg::PH_ESCAPE: begin
                    unique case (i_byte)
                        bmprle_pkg::ESC_EOL: o_rem_start = 1'b1;
                        bmprle_pkg::ESC_EOB: begin
                            n_done            = 1'b1;
                            o_meta_valid      = 1'b1;
                            o_meta.kind       = bmprle_pkg::RES_EOB;
                            o_meta.zero_color = 1'b1;
                            o_meta.start      = (64'(r_pos) > 64'(bmprle_pkg::START_MAX))
                                              ? bmprle_pkg::START_MAX
                                              : bmprle_pkg::START_W'(r_pos);
                        end
                        bmprle_pkg::ESC_DELTA: ;
                        default: begin
                            n_lit = i_byte;
                            n_pad = i_byte[0];
                        end
                    endcase
                end
                bmprle_pkg::PH_DELTA_X: n_dcol = i_byte;
                bmprle_pkg::PH_DELTA_Y: begin
                    n_dpend = 1'b1;
                    n_dadd  = w_dadd_n;
                end
                default: n_pad = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bmprle_pkg::PH_FIRST;
            r_held  <= '0;
            r_dcol  <= '0;
            r_lit   <= '0;
            r_pad   <= 1'b0;
            r_pos   <= '0;
            r_done  <= 1'b1;
            r_dpend <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_dcol  <= n_dcol;
            r_lit   <= n_lit;
            r_pad   <= n_pad;
            r_pos   <= n_pos;
            r_done  <= n_done;
            r_dpend <= n_dpend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dadd <= n_dadd;
    end

    assign o_pos = r_pos;

endmodule

// ----- rtl/core/bmp_rle8_palette_decoder.sv -----
// BMP RLE8 decoder with a 256-entry RGB palette.
// Input channel (i_in_valid / o_in_ready): kind 0 writes palette entry
// i_palette_index, kind 1 feeds one compressed byte, kind 2 starts an image
// and yields a whole-frame fill with palette entry 0. Kind 3 is dropped.
// Output channel (o_out_valid / i_out_ready): fills, pixel runs (linear start
// pixel, length, colour) and the end-of-bitmap marker, at most one per item.
// Config channel (i_cfg_valid / o_cfg_ready): index 0 image width, index 1
// image height; write only between items.
// A result passes the lookup stage and then the output queue before it is shown.
// Throughput: one item per cycle; the colour comes from one palette RAM read
// per item. An end-of-line escape holds o_in_ready low while a bit-serial
// unit forms position mod width. A config write holds o_in_ready low while
// the frame size product settles.
// Reset: parser back to its first phase, position 0, no image active; stream
// bytes are dropped until a start item. Palette contents are kept.
// Stall: a two-entry output queue plus one lookup stage absorb a stalled
// receiver; when both are full o_in_ready drops, nothing is lost.
`include "bmp_rle8_palette_decoder_macros.svh"

module bmp_rle8_palette_decoder #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_kind,
    input  logic [7:0]                         i_stream_byte,
    input  logic [bmprle_pkg::PAL_AW-1:0]      i_palette_index,
    input  logic [bmprle_pkg::COLOR_W-1:0]     i_palette_color,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [1:0]                         o_result_kind,
    output logic [bmprle_pkg::START_W-1:0]     o_start_pixel,
    output logic [bmprle_pkg::LEN_W-1:0]       o_run_length,
    output logic [7:0]                         o_red,
    output logic [7:0]                         o_green,
    output logic [7:0]                         o_blue,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_cfg_index,
    input  logic [bmprle_pkg::CFG_DW-1:0]      i_cfg_data
);

    localparam int EW = $clog2(MAX_WIDTH + 1);
    localparam int EH = $clog2(MAX_HEIGHT + 1);
    localparam longint unsigned FRAME_MAX = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
    localparam int PW = $clog2(FRAME_MAX + 1);

    // Effective geometry
    logic [EW-1:0]    r_eff_w;
    logic [EH-1:0]    r_eff_h;
    logic [PW-1:0]    r_frame;
    logic             r_cfg_settle;
    logic [EW-1:0]    w_cfg_w;
    logic [EH-1:0]    w_cfg_h;
    logic [EW+EH-1:0] w_prod;
    logic             w_cfg_accept;

    // Handshake and pipeline
    logic                           w_in_ready;
    logic                           w_in_accept;
    logic                           w_meta_valid;
    bmprle_pkg::t_meta              w_meta;
    logic [bmprle_pkg::PAL_AW-1:0]  w_rd_addr;
    logic [bmprle_pkg::COLOR_W-1:0] w_rd_data;
    logic                           w_rem_start;
    logic                           w_rem_busy;
    logic                           w_rem_done;
    logic [EW-1:0]                  w_rem;
    logic [PW-1:0]                  w_pos;

    logic                r_a_valid, n_a_valid;
    bmprle_pkg::t_meta   r_a_meta;
    bmprle_pkg::t_result r_q [2];
    logic                r_wr_ptr, r_rd_ptr;
    logic [1:0]          r_count;
    logic                w_q_full;
    logic                w_a_move;
    logic                w_pop;
    bmprle_pkg::t_result w_push_item;
    bmprle_pkg::t_result w_head;

    // Clamp written geometry to 1..MAX
    always_comb begin
        w_cfg_accept = i_cfg_valid && o_cfg_ready;
        w_cfg_w = (i_cfg_data == '0) ? EW'(1)
                : (32'(i_cfg_data) > 32'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(i_cfg_data);
        w_cfg_h = (i_cfg_data == '0) ? EH'(1)
                : (32'(i_cfg_data) > 32'(MAX_HEIGHT)) ? EH'(MAX_HEIGHT) : EH'(i_cfg_data);
        w_prod  = (EW+EH)'(r_eff_w) * (EW+EH)'(r_eff_h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w      <= EW'(1);
            r_eff_h      <= EH'(1);
            r_frame      <= PW'(1);
            r_cfg_settle <= 1'b0;
        end else begin
            r_cfg_settle <= w_cfg_accept;
            r_frame      <= PW'(w_prod);
            if (w_cfg_accept && (i_cfg_index == bmprle_pkg::CFG_IDX_WIDTH)) begin
                r_eff_w <= w_cfg_w;
            end
            if (w_cfg_accept && (i_cfg_index == bmprle_pkg::CFG_IDX_HEIGHT)) begin
                r_eff_h <= w_cfg_h;
            end
        end
    end

    // Input and config flow control
    always_comb begin
        w_q_full    = (r_count == 2'd2);
        w_a_move    = r_a_valid && !w_q_full;
        w_in_ready  = !w_rem_busy && !w_rem_done && !r_cfg_settle && !(r_a_valid && w_q_full);
        w_in_accept = i_in_valid && w_in_ready;
        w_pop       = o_out_valid && i_out_ready;
    end

    assign o_in_ready  = w_in_ready;
    assign o_cfg_ready = !w_rem_busy && !w_rem_done;

    bmprle_palette_ram u_palette (
        .i_clk   (i_clk),
        .i_we    (w_in_accept && (i_kind == bmprle_pkg::KIND_PALETTE)),
        .i_waddr (i_palette_index),
        .i_wdata (i_palette_color),
        .i_re    (w_in_accept),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    bmprle_parser #(
        .EW (EW),
        .PW (PW)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_in_accept),
        .i_kind       (i_kind),
        .i_byte       (i_stream_byte),
        .i_eff_w      (r_eff_w),
        .i_frame      (r_frame),
        .i_rem_done   (w_rem_done),
        .i_rem        (w_rem),
        .o_meta_valid (w_meta_valid),
        .o_meta       (w_meta),
        .o_rd_addr    (w_rd_addr),
        .o_rem_start  (w_rem_start),
        .o_pos        (w_pos)
    );

    bmprle_rem_unit #(
        .EW (EW),
        .PW (PW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (w_pos),
        .i_divisor  (r_eff_w),
        .o_busy     (w_rem_busy),
        .o_done     (w_rem_done),
        .o_rem      (w_rem)
    );

    // Lookup stage: descriptor waits here for the palette read data
    always_comb begin
        n_a_valid = r_a_valid;
        if (w_meta_valid) begin
            n_a_valid = 1'b1;
        end else if (w_a_move) begin
            n_a_valid = 1'b0;
        end
        w_push_item.kind  = r_a_meta.kind;
        w_push_item.start = r_a_meta.start;
        w_push_item.len   = r_a_meta.len;
        w_push_item.color = r_a_meta.zero_color ? '0 : w_rd_data;
        w_head            = r_q[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_wr_ptr  <= 1'b0;
            r_rd_ptr  <= 1'b0;
            r_count   <= '0;
        end else begin
            r_a_valid <= n_a_valid;
            if (w_a_move) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, w_a_move} - {1'b0, w_pop};
        end
    end

    // Payload of the lookup stage and the output queue
    always_ff @(posedge i_clk) begin
        if (w_meta_valid) begin
            r_a_meta <= w_meta;
        end
        if (w_a_move) begin
            r_q[r_wr_ptr] <= w_push_item;
        end
    end

    assign o_out_valid   = (r_count != '0);
    assign o_result_kind = w_head.kind;
    assign o_start_pixel = w_head.start;
    assign o_run_length  = w_head.len;
    assign o_red         = w_head.color[23:16];
    assign o_green       = w_head.color[15:8];
    assign o_blue        = w_head.color[7:0];

    `BMPRLE_ASSERT_NOW(a_queue_bound, 1'b1, r_count != 2'd3, "output queue overfilled")
    `BMPRLE_ASSERT_NEXT(a_lookup_hold, r_a_valid && w_q_full, r_a_valid && $stable(r_a_meta), "lookup stage lost an item")
    `BMPRLE_ASSERT_NEXT(a_eol_stall, w_rem_start, !o_in_ready && !o_cfg_ready, "input open during line end")

endmodule
